FILE: sv/counting_semaphore_table_core_defines.svh
// Assertion macros for the semaphore table core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CSEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/csem_pkg.sv
// Shared constants, codes and control types of the semaphore table core.
// No dependencies; imported by every module of the core.
package csem_pkg;

  localparam int NUM_SEMS  = 32;
  localparam int NUM_PROCS = 16;
  localparam int SEM_IW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PROC_IW   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] FUNC_NEW = 2'd0;
  localparam logic [1:0] FUNC_P   = 2'd1;
  localparam logic [1:0] FUNC_V   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic signed [15:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [15:0] CNT_MIN = 16'sh8000;

  typedef struct packed {
    logic load;    // capture the accepted request
    logic rd;      // read table entries into the operand stage
    logic commit;  // write back and present the result
  } csem_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new beat this cycle
  } csem_sts_t;

endpackage

FILE: sv/csem_ctrl.sv
// Sequencer of the semaphore table core: accept, read, commit.
// Depends on csem_pkg; drives commands to csem_dpath.
module csem_ctrl import csem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  csem_sts_t sts,
  output csem_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // A new beat may enter while the previous one commits; hold off during reset.
  assign in_tready = rst_n && ((state_r == S_IDLE) || ((state_r == S_EXEC) && sts.out_free));
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.load   = accept;
    cmd.rd     = (state_r == S_READ);
    cmd.commit = (state_r == S_EXEC) && sts.out_free;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = accept ? S_READ : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/csem_dpath.sv
// Datapath of the semaphore table core: tables, free-slot search, count
// update, wait-queue links and the result register. Depends on csem_pkg.
module csem_dpath import csem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csem_cmd_t              cmd,
  output csem_sts_t              sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Tables
  logic [NUM_SEMS-1:0] used_r;
  logic [NUM_SEMS-1:0] nonempty_r;
  logic signed [15:0]  count_r [NUM_SEMS];
  logic [3:0]          head_r  [NUM_SEMS];
  logic [3:0]          tail_r  [NUM_SEMS];
  logic [3:0]          next_r  [NUM_PROCS];

  // Captured request
  logic [1:0]         func_r;
  logic [7:0]         sid_r;
  logic signed [15:0] init_r;
  logic [3:0]         pid_r;

  // Operand stage
  logic signed [15:0] cnt_rd_r;
  logic [3:0]         head_rd_r;
  logic [3:0]         tail_rd_r;
  logic [3:0]         nxt_rd_r;
  logic               ne_rd_r;
  logic               used_rd_r;
  logic               sid_ok_r;
  logic               free_found_r;
  logic [SEM_IW-1:0]  free_idx_r;

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SEM_IW-1:0]  sidx;
  logic               free_found;
  logic [SEM_IW-1:0]  free_idx;
  logic               sem_ok;
  logic               pid_ok;
  logic signed [15:0] cnt_dec;
  logic signed [15:0] cnt_inc;

  // Commit controls
  logic [SEM_IW-1:0]  widx;
  logic               wr_cnt;
  logic signed [15:0] cnt_wval;
  logic               wr_head;
  logic [3:0]         head_wval;
  logic               wr_tail;
  logic               wr_next;
  logic               set_used;
  logic               wr_ne;
  logic               ne_wval;
  logic [1:0]         st;
  logic [4:0]         new_id;
  logic               blocked;
  logic               wk_valid;
  logic [3:0]         wk_proc;

  assign sidx = sid_r[SEM_IW-1:0];

  // Lowest free slot: scan from the top so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SEM_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_tdata[1:0];
      sid_r  <= in_tdata[9:2];
      init_r <= in_tdata[25:10];
      pid_r  <= in_tdata[29:26];
    end
    if (cmd.rd) begin
      cnt_rd_r     <= count_r[sidx];
      head_rd_r    <= head_r[sidx];
      tail_rd_r    <= tail_r[sidx];
      nxt_rd_r     <= next_r[PROC_IW'(head_r[sidx])];
      ne_rd_r      <= nonempty_r[sidx];
      used_rd_r    <= used_r[sidx];
      sid_ok_r     <= ({1'b0, sid_r} < 9'(NUM_SEMS));
      free_found_r <= free_found;
      free_idx_r   <= free_idx;
    end
  end

  assign sem_ok  = sid_ok_r && used_rd_r;
  assign pid_ok  = ({5'b0, pid_r} < 9'(NUM_PROCS));
  assign cnt_dec = (cnt_rd_r != CNT_MIN) ? cnt_rd_r - 16'sd1 : cnt_rd_r;
  assign cnt_inc = (cnt_rd_r != CNT_MAX) ? cnt_rd_r + 16'sd1 : cnt_rd_r;

  always_comb begin
    widx      = sidx;
    wr_cnt    = 1'b0;
    cnt_wval  = cnt_dec;
    wr_head   = 1'b0;
    head_wval = pid_r;
    wr_tail   = 1'b0;
    wr_next   = 1'b0;
    set_used  = 1'b0;
    wr_ne     = 1'b0;
    ne_wval   = 1'b0;
    st        = ST_OK;
    new_id    = '0;
    blocked   = 1'b0;
    wk_valid  = 1'b0;
    wk_proc   = '0;
    case (func_r)
      FUNC_NEW: begin
        if (free_found_r) begin
          widx     = free_idx_r;
          set_used = 1'b1;
          wr_cnt   = 1'b1;
          cnt_wval = init_r;
          wr_ne    = 1'b1;
          ne_wval  = 1'b0;
          new_id   = 5'(free_idx_r);
        end else begin
          st = ST_FULL;
        end
      end
      FUNC_P: begin
        if (!sem_ok) begin
          st = ST_BAD_ID;
        end else begin
          wr_cnt   = 1'b1;
          cnt_wval = cnt_dec;
          if (cnt_dec < 0) begin
            blocked = 1'b1;
            if (pid_ok) begin
              // Append: link behind the tail, or start a fresh queue.
              wr_tail = 1'b1;
              wr_next = ne_rd_r;
              wr_head = !ne_rd_r;
              wr_ne   = 1'b1;
              ne_wval = 1'b1;
            end
          end
        end
      end
      FUNC_V: begin
        if (!sem_ok) begin
          st = ST_BAD_ID;
        end else begin
          wr_cnt   = 1'b1;
          cnt_wval = cnt_inc;
          if ((cnt_inc <= 0) && ne_rd_r) begin
            wk_valid = 1'b1;
            wk_proc  = head_rd_r;
            if (head_rd_r == tail_rd_r) begin
              wr_ne   = 1'b1;
              ne_wval = 1'b0;
            end else begin
              wr_head   = 1'b1;
              head_wval = nxt_rd_r;
            end
          end
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_cnt)  count_r[widx] <= cnt_wval;
      if (wr_head) head_r[widx]  <= head_wval;
      if (wr_tail) tail_r[widx]  <= pid_r;
      if (wr_next) next_r[PROC_IW'(tail_rd_r)] <= pid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      nonempty_r <= '0;
    end else if (cmd.commit) begin
      if (set_used) used_r[widx]     <= 1'b1;
      if (wr_ne)    nonempty_r[widx] <= ne_wval;
    end
  end

  // Hold the result until taken; a commit refills it in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {3'b0, wk_proc, wk_valid, blocked, new_id, st};
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

FILE: sv/counting_semaphore_table_core.sv
// Semaphore table core. A beat passes the request register, the operand stage
// (table read) and the commit, which writes back and loads the result register;
// a stalled result beat holds the commit. A new request may be accepted while the
// previous one commits. Reset clears the slot-used and queue-nonempty flags, the
// sequencer and the result valid; counts and queue links are undefined until written.
`include "counting_semaphore_table_core_defines.svh"
module counting_semaphore_table_core import csem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] func, [9:2] sem_id, [25:10] init_value, [29:26] proc_id, [31:30] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] status, [6:2] new_id, [7] blocked, [8] woken_valid, [12:9] woken_proc,
  // [15:13] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  csem_cmd_t cmd;
  csem_sts_t sts;

  csem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csem_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `CSEM_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "commit into a busy result register")
  `CSEM_ASSERT_NEXT(a_accept_reads, in_tvalid && in_tready, cmd.rd, "accepted beat not read")
  `CSEM_ASSERT_NEXT(a_read_commits, cmd.rd, cmd.commit == sts.out_free, "read not followed by commit")
  `CSEM_ASSERT_NEXT(a_commit_valid, cmd.commit, out_tvalid, "commit produced no result beat")

endmodule

FILE: bench/sem_table_checker.sv
// Result checker for the semaphore table core: predicts every request from
// the input beats and compares the output beats in order. Needs csem_pkg.
module sem_table_checker import csem_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [NUM_SEMS-1:0]    wake_unsafe,
  output int unsigned            results_due,
  output int unsigned            mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PROC_IW-1:0] proc_id;
    logic signed [15:0] init_value;
    logic [7:0]         sem_id;
    logic [1:0]         func;
  } sem_req_t;

  typedef struct packed {
    logic [PROC_IW-1:0] woken_proc;
    logic               woken_valid;
    logic               blocked;
    logic [SEM_IW-1:0]  new_id;
    logic [1:0]         status;
  } sem_resp_t;

  logic               slot_used     [NUM_SEMS];
  logic signed [15:0] sem_count     [NUM_SEMS];
  logic [PROC_IW-1:0] wait_head     [NUM_SEMS];
  logic [PROC_IW-1:0] wait_tail     [NUM_SEMS];
  logic               wait_nonempty [NUM_SEMS];
  logic [PROC_IW-1:0] next_proc     [NUM_PROCS];
  logic               next_proc_set [NUM_PROCS];

  sem_resp_t   due_results [$];
  sem_resp_t   got_beat;
  sem_resp_t   want_beat;
  int unsigned fail_total = 0;
  int          k;

  function automatic sem_resp_t apply_request(sem_req_t r);
    sem_resp_t         res;
    logic [SEM_IW-1:0] s;
    logic [PROC_IW-1:0] h;
    logic              found;
    int                i;
    res = '0;
    found = 1'b0;
    s = r.sem_id[SEM_IW-1:0];
    if (r.func == FUNC_NEW) begin
      res.status = ST_FULL;
      for (i = 0; i < NUM_SEMS; i++) begin
        if (!found && !slot_used[i]) begin
          found = 1'b1;
          slot_used[i] = 1'b1;
          sem_count[i] = r.init_value;
          wait_nonempty[i] = 1'b0;
          res.new_id = i[SEM_IW-1:0];
          res.status = ST_OK;
        end
      end
    end else if (r.func == FUNC_P || r.func == FUNC_V) begin
      if (r.sem_id >= NUM_SEMS || !slot_used[s]) begin
        res.status = ST_BAD_ID;
      end else if (r.func == FUNC_P) begin
        if (sem_count[s] != CNT_MIN) sem_count[s] = sem_count[s] - 16'sd1;
        if (sem_count[s] < 0) begin
          res.blocked = 1'b1;
          // append to the tail; a repeated waiter is relinked without checks
          if (wait_nonempty[s]) begin
            next_proc[wait_tail[s]] = r.proc_id;
            next_proc_set[wait_tail[s]] = 1'b1;
          end else begin
            wait_head[s] = r.proc_id;
            wait_nonempty[s] = 1'b1;
          end
          wait_tail[s] = r.proc_id;
        end
      end else begin
        if (sem_count[s] != CNT_MAX) sem_count[s] = sem_count[s] + 16'sd1;
        if (sem_count[s] <= 0 && wait_nonempty[s]) begin
          h = wait_head[s];
          res.woken_valid = 1'b1;
          res.woken_proc = h;
          if (h == wait_tail[s]) wait_nonempty[s] = 1'b0;
          else wait_head[s] = next_proc[h];
        end
      end
    end
    return res;
  endfunction

  // A V that pops a head whose link was never written would read an
  // undefined entry; flag such slots so the stimulus steers around them.
  function automatic logic [NUM_SEMS-1:0] find_unsafe_wakes();
    logic [NUM_SEMS-1:0] v;
    logic signed [15:0]  c;
    int                  i;
    for (i = 0; i < NUM_SEMS; i++) begin
      c = (sem_count[i] == CNT_MAX) ? sem_count[i] : sem_count[i] + 16'sd1;
      v[i] = slot_used[i] && wait_nonempty[i] && (c <= 0) &&
             (wait_head[i] != wait_tail[i]) && !next_proc_set[wait_head[i]];
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < NUM_SEMS; k++) begin
        slot_used[k] = 1'b0;
        wait_nonempty[k] = 1'b0;
        sem_count[k] = '0;
        wait_head[k] = '0;
        wait_tail[k] = '0;
      end
      for (k = 0; k < NUM_PROCS; k++) begin
        next_proc[k] = '0;
        next_proc_set[k] = 1'b0;
      end
      due_results.delete();
      wake_unsafe <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_request(sem_req_t'(in_tdata[29:0])));
        wake_unsafe <= find_unsafe_wakes();
      end
      if (out_tvalid && out_tready) begin
        got_beat = sem_resp_t'(out_tdata[12:0]);
        if (due_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result beat: status %0d new_id %0d blocked %0b woken %0b/%0d",
                     got_beat.status, got_beat.new_id, got_beat.blocked,
                     got_beat.woken_valid, got_beat.woken_proc);
        end else begin
          want_beat = due_results.pop_front();
          if (got_beat !== want_beat) begin
            fail_total++;
            if (fail_total <= 10) begin
              $write("result mismatch: expected status %0d new_id %0d blocked %0b woken %0b/%0d,",
                     want_beat.status, want_beat.new_id, want_beat.blocked,
                     want_beat.woken_valid, want_beat.woken_proc);
              $display(" got status %0d new_id %0d blocked %0b woken %0b/%0d",
                       got_beat.status, got_beat.new_id, got_beat.blocked,
                       got_beat.woken_valid, got_beat.woken_proc);
            end
          end
        end
      end
    end
    results_due <= due_results.size();
    mismatch_count <= fail_total;
  end

endmodule

FILE: bench/tb_top.sv
// Top of the semaphore table bench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Needs csem_pkg, sem_table_checker and counting_semaphore_table_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csem_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int RANDOM_ITEMS       = 1950;
  localparam int CALM_TAIL          = 300;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int DRAIN_CYCLES       = 8;

  typedef struct packed {
    logic [PROC_IW-1:0] proc_id;
    logic signed [15:0] init_value;
    logic [7:0]         sem_id;
    logic [1:0]         func;
  } sem_req_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [NUM_SEMS-1:0]    wake_unsafe;
  int unsigned            results_due;
  int unsigned            mismatch_count;

  int          idle_pct;
  int          n_new;
  int          stall_left;
  int unsigned idle_cycles;
  int          n;

  counting_semaphore_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sem_table_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .wake_unsafe    (wake_unsafe),
    .results_due    (results_due),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sem_req_t mk(logic [1:0] f, logic [7:0] sid,
                                  logic signed [15:0] init, logic [PROC_IW-1:0] pid);
    sem_req_t r;
    r.func = f;
    r.sem_id = sid;
    r.init_value = init;
    r.proc_id = pid;
    return r;
  endfunction

  function automatic int live_slots();
    return (n_new < NUM_SEMS) ? n_new : NUM_SEMS;
  endfunction

  // Mostly P and V on allocated slots, with allocations, bad ids and
  // unknown operations mixed in; unused fields carry random noise.
  function automatic sem_req_t random_request();
    sem_req_t r;
    int       pick;
    int       n_live;
    n_live = live_slots();
    r = sem_req_t'(30'($urandom));
    r.func = ($urandom_range(1) != 0) ? FUNC_P : FUNC_V;
    pick = $urandom_range(99);
    if (pick < 8 || n_live == 0) begin
      r.func = FUNC_NEW;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: r.init_value = 16'(int'($urandom_range(8)) - 4);
        6, 7, 8:          r.init_value = 16'($urandom);
        default:          r.init_value = ($urandom_range(1) != 0) ? CNT_MAX : CNT_MIN;
      endcase
    end else if (pick < 14) begin
      r.sem_id = 8'($urandom_range(255, n_live));
    end else if (pick < 17) begin
      r.func = FUNC_UNUSED;
    end else begin
      r.sem_id = 8'($urandom_range(n_live - 1));
    end
    return r;
  endfunction

  task automatic issue(input sem_req_t r);
    int n_live;
    int start;
    int idx;
    int j;
    logic found;
    // the checker has absorbed the previous beat by this edge
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct)
      repeat ($urandom_range(9, 1)) @(posedge clk);
    if (r.func == FUNC_V && r.sem_id < NUM_SEMS && wake_unsafe[r.sem_id[SEM_IW-1:0]]) begin
      n_live = live_slots();
      start = $urandom_range(n_live - 1);
      found = 1'b0;
      for (j = 0; j < n_live; j++) begin
        idx = (start + j) % n_live;
        if (!found && !wake_unsafe[idx]) begin
          r.sem_id = 8'(idx);
          found = 1'b1;
        end
      end
      if (!found) r.func = FUNC_P;
    end
    if (r.func == FUNC_NEW) n_new++;
    in_tdata <= {2'b00, r};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
  endtask

  // Result side back-pressure: random low bursts of out_tready.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
        stall_left = $urandom_range(9, 1) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_pct = 20;
    n_new = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // bad ids on an empty table, unknown operation
    issue(mk(FUNC_P, 8'd0, 16'sd0, 4'd0));
    issue(mk(FUNC_V, 8'hff, 16'hffff, 4'hf));
    issue(mk(FUNC_UNUSED, 8'haa, 16'h5555, 4'ha));
    // saturation at the top, then at the bottom with a blocked caller
    issue(mk(FUNC_NEW, 8'h55, CNT_MAX, 4'd0));
    issue(mk(FUNC_V, 8'd0, 16'sd0, 4'd0));
    issue(mk(FUNC_P, 8'd0, 16'sd0, 4'd0));
    issue(mk(FUNC_NEW, 8'd0, CNT_MIN, 4'd15));
    issue(mk(FUNC_P, 8'd1, 16'sd0, 4'd15));
    // wait queue with a repeated waiter, then drain past zero
    issue(mk(FUNC_NEW, 8'd0, 16'sd0, 4'd0));
    issue(mk(FUNC_P, 8'd2, 16'sd0, 4'd3));
    issue(mk(FUNC_P, 8'd2, 16'sd0, 4'd5));
    issue(mk(FUNC_P, 8'd2, 16'sd0, 4'd3));
    repeat (4) issue(mk(FUNC_V, 8'd2, 16'sd0, 4'd0));
    // ids just past the table and on an unused slot, then a V that wakes the blocked caller
    issue(mk(FUNC_P, 8'd32, 16'sd0, 4'd1));
    issue(mk(FUNC_P, 8'd31, 16'sd0, 4'd1));
    issue(mk(FUNC_V, 8'd1, 16'sd0, 4'd0));
    // V on an empty queue reaching zero
    issue(mk(FUNC_NEW, 8'd0, -16'sd1, 4'd0));
    issue(mk(FUNC_V, 8'd3, 16'sd0, 4'd0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;
      issue(random_request());
    end

    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
